### rtl/core/i2cms_pkg.sv
// Package with the command codes, the queued command record and the queue port records.
package i2cms_pkg;

	// Command codes as they arrive on the request channel.
	typedef enum logic [2:0] {
		OP_START    = 3'd0,
		OP_STOP     = 3'd1,
		OP_WRITE    = 3'd2,
		OP_READ     = 3'd3,
		OP_SEND_ACK = 3'd4,
		OP_RECV_ACK = 3'd5
	} op_t;

	// Steps within one bit slot; start uses all four as its own sequence.
	localparam logic [1:0] PH_SETUP = 2'd0;
	localparam logic [1:0] PH_HIGH  = 2'd1;
	localparam logic [1:0] PH_LOW   = 2'd2;
	localparam logic [1:0] PH_END   = 2'd3;

	localparam logic [2:0] LAST_BIT = 3'd7;
	localparam int unsigned QUEUE_DEPTH = 2;

	// One classified command as it waits in the queue.
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       ack;
	} cmd_t;

	// Write side of the queue.
	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_wr_t;

	// Read side of the queue.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_rd_t;

endpackage

### rtl/core/i2cms_if.sv
// Handshake interfaces for the request and result channels.
interface i2cms_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [7:0] tx_byte;
	logic       ack_level;
	logic [7:0] line_levels;

	modport source (output valid, req_type, tx_byte, ack_level, line_levels, input ready);
	modport sink (input valid, req_type, tx_byte, ack_level, line_levels, output ready);
endinterface

interface i2cms_rsp_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic [7:0] rx_byte;
	logic       ack_seen;
	logic       last;

	modport source (output valid, scl_level, sda_level, rx_byte, ack_seen, last, input ready);
	modport sink (input valid, scl_level, sda_level, rx_byte, ack_seen, last, output ready);
endinterface

### rtl/core/i2c_master_bit_sequencer_top.sv
// Top level of the I2C master line sequencer: front end, command queue and sequencer.
//
//  channel | direction | payload                                          | items
//  req     | in        | req_type, tx_byte, ack_level, line_levels        | one command
//  rsp     | out       | scl_level, sda_level, rx_byte, ack_seen, last    | one pin write
//
// Each command yields its results one per cycle unless stalled: start 4, stop 3,
// write byte 24, read byte 17, send and receive ack 3; request codes 6 and 7 yield none.
// The sequencer's step counter sets the rate; a two-entry queue lets new commands be
// taken while the current one is still being played out.
// Reset leaves both lines released (high) and empties the queue and output register.
// A stalled result holds in the output register and stops the sequencer only.
module i2c_master_bit_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	i2cms_req_if.sink   req,
	i2cms_rsp_if.source rsp
);
	import i2cms_pkg::*;

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  q_pop;

	i2cms_front u_front (
		.req    (req),
		.q_full (q_full),
		.wr     (q_wr)
	);

	i2cms_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.full   (q_full),
		.rd     (q_rd)
	);

	i2cms_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (q_rd),
		.pop    (q_pop),
		.rsp    (rsp)
	);

endmodule

### rtl/core/i2cms_front.sv
// Front end: accepts requests, drops unused codes and builds the queued command record.
module i2cms_front (
	i2cms_req_if.sink     req,
	input  logic          q_full,
	output i2cms_pkg::q_wr_t wr
);
	import i2cms_pkg::*;

	logic legal;
	op_t  op;

	// Take a request whenever the queue has room.
	assign req.ready = ~q_full;

	// Classify the request code; the two unused codes produce nothing.
	always_comb begin
		legal = 1'b1;
		op    = OP_START;
		case (req.req_type)
			OP_START:    op = OP_START;
			OP_STOP:     op = OP_STOP;
			OP_WRITE:    op = OP_WRITE;
			OP_READ:     op = OP_READ;
			OP_SEND_ACK: op = OP_SEND_ACK;
			OP_RECV_ACK: op = OP_RECV_ACK;
			default:     legal = 1'b0;
		endcase
	end

	// Keep only the operand the command needs.
	always_comb begin
		wr.push     = req.valid & ~q_full & legal;
		wr.cmd.op   = op;
		wr.cmd.data = (op == OP_READ) ? req.line_levels : req.tx_byte;
		wr.cmd.ack  = (op == OP_RECV_ACK) ? req.line_levels[0] : req.ack_level;
	end

endmodule

### rtl/core/i2cms_cmd_queue.sv
// Two-entry command queue between the front end and the line sequencer.
module i2cms_cmd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  i2cms_pkg::q_wr_t wr,
	input  logic             pop,
	output logic             full,
	output i2cms_pkg::q_rd_t rd
);
	import i2cms_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_pop;

	assign full     = (count_q == (PTR_W + 1)'(QUEUE_DEPTH)) ? 1'b1 : 1'b0;
	assign rd.valid = (count_q != '0);
	assign rd.cmd   = mem_q[rd_ptr_q];
	assign do_pop   = pop & rd.valid;

	// Pointer and fill-count bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr.push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!wr.push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr.push)
			mem_q[wr_ptr_q] <= wr.cmd;
	end

endmodule

### rtl/core/i2cms_seq.sv
// Back end: plays out the head command, one pin write per cycle unless stalled.
module i2cms_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  i2cms_pkg::q_rd_t rd,
	output logic             pop,
	i2cms_rsp_if.source      rsp
);
	import i2cms_pkg::*;

	logic [1:0] phase_q;
	logic [2:0] bit_q;
	logic       scl_q;
	logic       sda_q;
	logic       out_valid_q;
	logic       out_scl_q;
	logic       out_sda_q;
	logic [7:0] out_rx_q;
	logic       out_ack_q;
	logic       out_last_q;

	logic       emit;
	logic       is_scl;
	logic       wr_val;
	logic       last_c;
	logic [7:0] rx_c;
	logic       ack_c;
	logic [1:0] phase_d;
	logic [2:0] bit_d;
	logic       scl_d;
	logic       sda_d;

	// A result is produced when a command waits and the output register is free.
	assign emit = rd.valid & (~out_valid_q | rsp.ready);
	assign pop  = emit & last_c;

	// Decode the current step into one pin write.
	always_comb begin
		is_scl = 1'b0;
		wr_val = 1'b1;
		last_c = 1'b0;
		rx_c   = '0;
		ack_c  = 1'b0;
		case (rd.cmd.op)
			OP_START: begin
				is_scl = phase_q[0];
				wr_val = (phase_q == PH_SETUP) || (phase_q == PH_HIGH);
				last_c = (phase_q == PH_END);
			end
			OP_STOP: begin
				is_scl = (phase_q == PH_HIGH);
				wr_val = (phase_q != PH_SETUP);
				last_c = (phase_q == PH_LOW);
			end
			OP_WRITE, OP_READ, OP_SEND_ACK, OP_RECV_ACK: begin
				is_scl = (phase_q != PH_SETUP);
				if (phase_q == PH_SETUP) begin
					// Data line set-up for this slot.
					case (rd.cmd.op)
						OP_WRITE:    wr_val = rd.cmd.data[~bit_q];
						OP_SEND_ACK: wr_val = rd.cmd.ack;
						default:     wr_val = 1'b1;
					endcase
				end else begin
					wr_val = (phase_q == PH_HIGH);
				end
				if (phase_q == PH_LOW) begin
					if ((rd.cmd.op == OP_WRITE) || (rd.cmd.op == OP_READ))
						last_c = (bit_q == LAST_BIT);
					else
						last_c = 1'b1;
				end
				if (last_c && (rd.cmd.op == OP_READ))
					rx_c = rd.cmd.data;
				if (last_c && (rd.cmd.op == OP_RECV_ACK))
					ack_c = rd.cmd.ack;
			end
			default: last_c = 1'b1;
		endcase
	end

	// Step counters and the line levels after this write.
	always_comb begin
		phase_d = phase_q + 1'b1;
		bit_d   = bit_q;
		if (last_c) begin
			phase_d = PH_SETUP;
			bit_d   = '0;
		end else if ((phase_q == PH_LOW) &&
				((rd.cmd.op == OP_WRITE) || (rd.cmd.op == OP_READ))) begin
			bit_d   = bit_q + 1'b1;
			phase_d = (rd.cmd.op == OP_READ) ? PH_HIGH : PH_SETUP;
		end
		scl_d = is_scl ? wr_val : scl_q;
		sda_d = is_scl ? sda_q : wr_val;
	end

	// Sequencer state and line levels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SETUP;
			bit_q       <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				phase_q <= phase_d;
				bit_q   <= bit_d;
				scl_q   <= scl_d;
				sda_q   <= sda_d;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_scl_q  <= scl_d;
			out_sda_q  <= sda_d;
			out_rx_q   <= rx_c;
			out_ack_q  <= ack_c;
			out_last_q <= last_c;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.scl_level = out_scl_q;
	assign rsp.sda_level = out_sda_q;
	assign rsp.rx_byte   = out_rx_q;
	assign rsp.ack_seen  = out_ack_q;
	assign rsp.last      = out_last_q;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the I2C master line sequencer: directed commands, then random transactions.
`timescale 1ns / 100ps

module tb_top;
	import i2cms_pkg::*;

	// Request codes that the sequencer must ignore.
	localparam logic [2:0] CODE_SPARE_LO = 3'd6;
	localparam logic [2:0] CODE_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS  = 470;
	localparam int DRAIN_CYCLES  = 64;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DIRECTED_ROWS = 23;

	// One command as sent, with optional typed values for its final pin write.
	typedef struct packed {
		logic [2:0] code;
		logic [7:0] tx_byte;
		logic       ack_level;
		logic [7:0] line_levels;
		logic       typed;
		logic [7:0] final_rx;
		logic       final_ack;
	} cmd_row_t;

	// One expected pin write.
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic [7:0] rx;
		logic       ack;
		logic       last;
	} pin_write_t;

	// Directed commands: extremes, every operation, spare codes and ignored fields.
	localparam cmd_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		'{OP_START,      8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0},
		'{OP_WRITE,      8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0},
		'{OP_RECV_ACK,   8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0},
		'{OP_WRITE,      8'hFF, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0},
		'{OP_RECV_ACK,   8'h00, 1'b0, 8'h01, 1'b1, 8'h00, 1'b1},
		'{OP_WRITE,      8'hA5, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{OP_RECV_ACK,   8'hFF, 1'b1, 8'hFE, 1'b1, 8'h00, 1'b0},
		'{OP_READ,       8'h00, 1'b0, 8'hFF, 1'b1, 8'hFF, 1'b0},
		'{OP_SEND_ACK,   8'hFF, 1'b0, 8'hFF, 1'b1, 8'h00, 1'b0},
		'{OP_READ,       8'hFF, 1'b1, 8'h00, 1'b1, 8'h00, 1'b0},
		'{OP_SEND_ACK,   8'h00, 1'b1, 8'h00, 1'b1, 8'h00, 1'b0},
		'{OP_READ,       8'h00, 1'b0, 8'h5A, 1'b0, 8'h00, 1'b0},
		'{CODE_SPARE_LO, 8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0},
		'{CODE_SPARE_HI, 8'hFF, 1'b1, 8'hFF, 1'b1, 8'h00, 1'b0},
		'{OP_STOP,       8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0},
		'{OP_STOP,       8'hFF, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0},
		'{OP_WRITE,      8'h80, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0},
		'{OP_START,      8'hFF, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0},
		'{OP_RECV_ACK,   8'h00, 1'b0, 8'hFF, 1'b1, 8'h00, 1'b1},
		'{OP_SEND_ACK,   8'hFF, 1'b0, 8'hFF, 1'b1, 8'h00, 1'b0},
		'{OP_READ,       8'hFF, 1'b1, 8'h01, 1'b1, 8'h01, 1'b0},
		'{CODE_SPARE_LO, 8'h55, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0},
		'{OP_STOP,       8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0}
	};

	logic clk;
	logic arst_n;

	i2cms_req_if req_ch ();
	i2cms_rsp_if rsp_ch ();

	i2c_master_bit_sequencer_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	cmd_row_t   commands_to_send[$];
	pin_write_t pin_writes_due[$];

	// Line levels as the sequencer should hold them.
	logic line_scl = 1'b1;
	logic line_sda = 1'b1;

	int error_count = 0;
	int cycle_count = 0;
	int cmds_accepted = 0;
	int spare_accepted = 0;
	int pin_writes_checked = 0;
	int random_items = 0;

	// Clock and reset.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$display("Run timed out after %0d cycles with %0d pin writes still due.",
				cycle_count, pin_writes_due.size());
			$finish;
		end
	end

	// Queue a pin write with the current line levels.
	function automatic void push_pin(input logic [7:0] rx, input logic ack, input logic last);
		pin_write_t pw;
		pw.scl  = line_scl;
		pw.sda  = line_sda;
		pw.rx   = rx;
		pw.ack  = ack;
		pw.last = last;
		pin_writes_due.push_back(pw);
	endfunction

	// Work out the pin writes that one accepted command causes.
	function automatic void play_command(input cmd_row_t row);
		logic [7:0] gathered;
		int         first_new;
		pin_write_t pw;
		gathered  = 8'h00;
		first_new = pin_writes_due.size();
		case (row.code)
			OP_START: begin
				line_sda = 1'b1; push_pin(8'h00, 1'b0, 1'b0);
				line_scl = 1'b1; push_pin(8'h00, 1'b0, 1'b0);
				line_sda = 1'b0; push_pin(8'h00, 1'b0, 1'b0);
				line_scl = 1'b0; push_pin(8'h00, 1'b0, 1'b1);
			end
			OP_STOP: begin
				line_sda = 1'b0; push_pin(8'h00, 1'b0, 1'b0);
				line_scl = 1'b1; push_pin(8'h00, 1'b0, 1'b0);
				line_sda = 1'b1; push_pin(8'h00, 1'b0, 1'b1);
			end
			OP_WRITE: begin
				for (int i = 7; i >= 0; i--) begin
					line_sda = row.tx_byte[i]; push_pin(8'h00, 1'b0, 1'b0);
					line_scl = 1'b1;           push_pin(8'h00, 1'b0, 1'b0);
					line_scl = 1'b0;           push_pin(8'h00, 1'b0, i == 0);
				end
			end
			OP_READ: begin
				line_sda = 1'b1; push_pin(8'h00, 1'b0, 1'b0);
				for (int i = 7; i >= 0; i--) begin
					line_scl = 1'b1; push_pin(8'h00, 1'b0, 1'b0);
					gathered[i] = row.line_levels[i];
					line_scl = 1'b0;
					push_pin((i == 0) ? gathered : 8'h00, 1'b0, i == 0);
				end
			end
			OP_SEND_ACK: begin
				line_sda = row.ack_level; push_pin(8'h00, 1'b0, 1'b0);
				line_scl = 1'b1;          push_pin(8'h00, 1'b0, 1'b0);
				line_scl = 1'b0;          push_pin(8'h00, 1'b0, 1'b1);
			end
			OP_RECV_ACK: begin
				line_sda = 1'b1; push_pin(8'h00, 1'b0, 1'b0);
				line_scl = 1'b1; push_pin(8'h00, 1'b0, 1'b0);
				line_scl = 1'b0; push_pin(8'h00, row.line_levels[0], 1'b1);
			end
			default: begin
				// Spare codes leave the lines alone and cause nothing.
			end
		endcase
		// Typed rows fix the received fields of the final pin write directly.
		if (row.typed && pin_writes_due.size() > first_new) begin
			pw     = pin_writes_due.pop_back();
			pw.rx  = row.final_rx;
			pw.ack = row.final_ack;
			pin_writes_due.push_back(pw);
		end
	endfunction

	// Append a command; the byte and line fields are random, so unused ones vary too.
	function automatic void add_cmd(input logic [2:0] code, input logic ackl);
		cmd_row_t row;
		row.code        = code;
		row.tx_byte     = 8'($urandom);
		row.ack_level   = ackl;
		row.line_levels = 8'($urandom);
		row.typed       = 1'b0;
		row.final_rx    = 8'h00;
		row.final_ack   = 1'b0;
		commands_to_send.push_back(row);
		if (code != CODE_SPARE_LO && code != CODE_SPARE_HI)
			random_items++;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		error_count++;
		$display("[%0d] pin write %0d: %s is %0h, expected %0h",
			cycle_count, pin_writes_checked, field, got, want);
	endtask

	// Result checker: each accepted pin write against the oldest expectation.
	always @(posedge clk) begin
		pin_write_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pin_writes_due.size() == 0) begin
				report_mismatch("unexpected item", 1, 0);
			end else begin
				want = pin_writes_due.pop_front();
				if (rsp_ch.scl_level !== want.scl)
					report_mismatch("scl_level", rsp_ch.scl_level, want.scl);
				if (rsp_ch.sda_level !== want.sda)
					report_mismatch("sda_level", rsp_ch.sda_level, want.sda);
				if (rsp_ch.rx_byte !== want.rx)
					report_mismatch("rx_byte", rsp_ch.rx_byte, want.rx);
				if (rsp_ch.ack_seen !== want.ack)
					report_mismatch("ack_seen", rsp_ch.ack_seen, want.ack);
				if (rsp_ch.last !== want.last)
					report_mismatch("last", rsp_ch.last, want.last);
			end
			pin_writes_checked++;
		end
	end

	// Receiver: stretches of full speed, light and heavy stalls, and long holds.
	initial begin : stall_results
		int mode;
		int left;
		mode = 0;
		left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(8, 80);
			end
			left--;
			case (mode)
				0:       rsp_ch.ready <= 1'b1;
				1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ch.ready <= (left % 16 == 0);
			endcase
		end
	end

	// Sender: builds the command list, then sends it in bursts with gaps.
	initial begin : drive_commands
		int   idx;
		int   burst_left;
		int   gap;
		int   nbytes;
		logic reading;
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= 3'd0;
		req_ch.tx_byte     <= 8'h00;
		req_ch.ack_level   <= 1'b0;
		req_ch.line_levels <= 8'h00;

		for (int r = 0; r < DIRECTED_ROWS; r++)
			commands_to_send.push_back(DIRECTED[r]);

		// Mostly complete transactions, with some loose commands as noise.
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 8) begin
				add_cmd(OP_START, 1'($urandom));
				add_cmd(OP_WRITE, 1'($urandom));
				reading = commands_to_send[commands_to_send.size() - 1].tx_byte[0];
				add_cmd(OP_RECV_ACK, 1'($urandom));
				nbytes = $urandom_range(0, 4);
				for (int k = 0; k < nbytes; k++) begin
					if (reading) begin
						add_cmd(OP_READ, 1'($urandom));
						// Acknowledge every byte but the last, with an odd flip now and then.
						add_cmd(OP_SEND_ACK, (k == nbytes - 1) ^ ($urandom_range(0, 7) == 0));
					end else begin
						add_cmd(OP_WRITE, 1'($urandom));
						add_cmd(OP_RECV_ACK, 1'($urandom));
					end
				end
				// Leaving out the stop makes the next start a repeated start.
				if ($urandom_range(0, 5) != 0)
					add_cmd(OP_STOP, 1'($urandom));
			end else begin
				repeat ($urandom_range(1, 3))
					add_cmd(3'($urandom_range(0, 7)), 1'($urandom));
			end
		end

		wait (arst_n === 1'b1);
		@(posedge clk);

		idx        = 0;
		burst_left = $urandom_range(1, 40);
		while (idx < commands_to_send.size()) begin
			req_ch.valid       <= 1'b1;
			req_ch.req_type    <= commands_to_send[idx].code;
			req_ch.tx_byte     <= commands_to_send[idx].tx_byte;
			req_ch.ack_level   <= commands_to_send[idx].ack_level;
			req_ch.line_levels <= commands_to_send[idx].line_levels;
			@(posedge clk);
			while (!req_ch.ready)
				@(posedge clk);
			play_command(commands_to_send[idx]);
			cmds_accepted++;
			if (commands_to_send[idx].code == CODE_SPARE_LO ||
				commands_to_send[idx].code == CODE_SPARE_HI)
				spare_accepted++;
			idx++;
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
				if (gap > 0) begin
					req_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		req_ch.valid <= 1'b0;

		// Drain: every expected pin write, then a quiet spell for stray items.
		while (pin_writes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands (%0d with spare codes) under random gaps and stalls.",
			cmds_accepted, spare_accepted);
		$display("Checked %0d pin writes field by field; %0d mismatches.",
			pin_writes_checked, error_count);
		if (error_count == 0 && pin_writes_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
